FILE: sv/rdf_pkg.sv
// Shared constants, widths and saturation helper for the reaction-diffusion row block.
// No dependencies; imported by rdf_qmul and reaction_diffusion_ftcs_row.
package rdf_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int IDX_W     = 2;
    localparam int SUM_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * DATA_W;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_DIFFUSION_GAIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_GROWTH_RATE      = 2'd1;
    localparam logic [IDX_W-1:0] REG_INVERSE_CAPACITY = 2'd2;
    localparam logic [IDX_W-1:0] REG_TIME_STEP        = 2'd3;

    // Register reset values (about 0.1, 0.2, 0.01 and 0.1 in Q16.16)
    localparam logic [CFG_W-1:0] RST_DIFFUSION_GAIN   = 31'd6554;
    localparam logic [CFG_W-1:0] RST_GROWTH_RATE      = 31'd13107;
    localparam logic [CFG_W-1:0] RST_INVERSE_CAPACITY = 31'd655;
    localparam logic [CFG_W-1:0] RST_TIME_STEP        = 31'd6554;

    // 1.0 in the working format
    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Clamp a widened sum to the signed data range
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] top_bits;
        top_bits = v[SUM_W-1:DATA_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat_sum = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_sum = SAT_MIN;
        end else begin
            sat_sum = SAT_MAX;
        end
    endfunction

endpackage

FILE: sv/rdf_qmul.sv
// Shared fixed-point multiplier: registered product, then floor shift and saturation.
// Depends on rdf_pkg. Both the full product and the scaled result are registered.
module rdf_qmul
    import rdf_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [DATA_W-1:0] o_q
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [DATA_W-1:0] n_q;
    logic signed [DATA_W-1:0] r_q;
    logic [PROD_W-DATA_W:0]   top_bits;

    // Shift right arithmetically (floor) and clamp to the data range
    always_comb begin
        prod_shift = r_prod >>> FRAC_BITS;
        top_bits   = prod_shift[PROD_W-1:DATA_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            n_q = prod_shift[DATA_W-1:0];
        end else if (prod_shift[PROD_W-1]) begin
            n_q = SAT_MIN;
        end else begin
            n_q = SAT_MAX;
        end
    end

    // Register the full product, then the scaled result
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_q    <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: sv/reaction_diffusion_ftcs_row.sv
// Top level of the FTCS reaction-diffusion row block: window, sequencer, output register.
// Depends on rdf_pkg and rdf_qmul.
//
// One explicit time step of 1-D reaction-diffusion with logistic growth on a streamed row
// of signed Q16.16 samples; tlast on the input marks the last sample of a row, tlast on the
// output marks the right boundary result. Both boundary points come out as zero, interior
// points as u + (Dg*lap + r*u*(1 - u*invK))*dt with saturation at every step. An interior
// point runs through five multiplies on one shared two-stage multiplier under a step
// sequencer: ten sequencer steps, then the load of the output register; the result is
// valid and, unless a boundary zero is owed, the input is ready again in the same cycle.
// The last sample of a row that has interior points loads that right boundary zero
// behind its result. A first sample, or the last sample of a two-sample row, goes
// straight to the output load; a second sample that does not end the row only fills the
// window. Output stalls hold the block in the output load until the register is free.
// The input is held off while a point is being worked; a finished result may still sit
// in the output register when the next sample is accepted. Rows of fewer than three
// samples give only zeros.
module reaction_diffusion_ftcs_row
    import rdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [31:0] sample
    input  logic              i_s_tlast,   // row_end
    // Output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // [31:0] updated_value
    output logic              o_m_tlast,   // row_done
    // Configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_PUT
    } t_state;

    // Sequencer steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DIFF  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RATIO = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RU    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_KEEP  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_REACT = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RATE  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DELTA = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd9;

    // Row position codes
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_INNER  = 2'd2;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]         r_gain;
    logic [CFG_W-1:0]         r_rate_cfg;
    logic [CFG_W-1:0]         r_invk;
    logic [CFG_W-1:0]         r_dt;

    logic [1:0]               r_pos;
    logic signed [DATA_W-1:0] r_left;
    logic signed [DATA_W-1:0] r_center;
    logic signed [DATA_W-1:0] r_u;
    logic signed [DATA_W-1:0] r_lap;
    logic signed [DATA_W-1:0] r_diff;
    logic signed [DATA_W-1:0] r_keep;
    logic signed [DATA_W-1:0] r_rate;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_res_last;
    logic                     r_pend;
    logic [STEP_W-1:0]        r_step;

    logic                     r_ov;
    logic [DATA_W-1:0]        r_odata;
    logic                     r_olast;

    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] lap;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [DATA_W-1:0] mul_q;
    logic                     in_xact;
    logic                     slot_free;

    assign sample    = i_s_tdata;
    assign in_xact   = i_s_tvalid && o_s_tready;
    assign slot_free = !r_ov || i_m_tready;

    // Laplacian numerator from the window and the incoming right sample
    assign lap = sat_sum(SUM_W'(r_left) + SUM_W'(sample) - (SUM_W'(r_center) <<< 1));

    // Select multiplier operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                STEP_DIFF: begin
                    mul_a = $signed({1'b0, r_gain});
                    mul_b = r_lap;
                end
                STEP_RATIO: begin
                    mul_a = r_u;
                    mul_b = $signed({1'b0, r_invk});
                end
                STEP_RU: begin
                    mul_a = $signed({1'b0, r_rate_cfg});
                    mul_b = r_u;
                end
                STEP_REACT: begin
                    mul_a = mul_q;
                    mul_b = r_keep;
                end
                STEP_DELTA: begin
                    mul_a = r_rate;
                    mul_b = $signed({1'b0, r_dt});
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    rdf_qmul u_qmul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_q   (mul_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    if (r_pos == POS_INNER) begin
                        n_state = S_MUL;
                    end else if (r_pos == POS_FIRST || i_s_tlast) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_MUL: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (slot_free && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, window, sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= POS_FIRST;
            r_pend     <= 1'b0;
            r_step     <= '0;
            r_ov       <= 1'b0;
            r_gain     <= RST_DIFFUSION_GAIN;
            r_rate_cfg <= RST_GROWTH_RATE;
            r_invk     <= RST_INVERSE_CAPACITY;
            r_dt       <= RST_TIME_STEP;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DIFFUSION_GAIN:   r_gain     <= i_cfg_data;
                    REG_GROWTH_RATE:      r_rate_cfg <= i_cfg_data;
                    REG_INVERSE_CAPACITY: r_invk     <= i_cfg_data;
                    REG_TIME_STEP:        r_dt       <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the output once taken, unless a new result is loaded behind it
            if (r_ov && i_m_tready && (r_state != S_PUT)) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        r_center <= sample;
                        unique case (r_pos)
                            POS_FIRST: begin
                                r_left     <= '0;
                                r_res      <= '0;
                                r_res_last <= i_s_tlast;
                                r_pend     <= 1'b0;
                                r_pos      <= i_s_tlast ? POS_FIRST : POS_SECOND;
                            end
                            POS_SECOND: begin
                                r_left     <= r_center;
                                r_res      <= '0;
                                r_res_last <= 1'b1;
                                r_pend     <= 1'b0;
                                r_pos      <= i_s_tlast ? POS_FIRST : POS_INNER;
                            end
                            default: begin
                                r_left <= r_center;
                                r_u    <= r_center;
                                r_lap  <= lap;
                                r_pend <= i_s_tlast;
                                r_step <= '0;
                                r_pos  <= i_s_tlast ? POS_FIRST : POS_INNER;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_step <= r_step + STEP_W'(1);
                    case (r_step)
                        STEP_RU:   r_diff <= mul_q;
                        STEP_KEEP: r_keep <= sat_sum(SUM_W'(FIX_ONE) - SUM_W'(mul_q));
                        STEP_RATE: r_rate <= sat_sum(SUM_W'(r_diff) + SUM_W'(mul_q));
                        STEP_LAST: begin
                            r_res      <= sat_sum(SUM_W'(r_u) + SUM_W'(mul_q));
                            r_res_last <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_PUT: begin
                    // Load the result, then the right boundary zero if one is owed
                    if (slot_free) begin
                        r_ov    <= 1'b1;
                        r_odata <= r_res;
                        r_olast <= r_res_last;
                        if (r_pend) begin
                            r_res      <= '0;
                            r_res_last <= 1'b1;
                            r_pend     <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

`ifndef ASSERT_OFF
    // The end of a row is always a boundary zero
    a_boundary_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == '0))
        else $error("row end result is not zero");

    // An owed boundary result keeps the input held off
    a_pend_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_s_tready)
        else $error("input ready with a boundary result still owed");

    // The sequencer never runs past its last step
    a_step_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step <= STEP_LAST))
        else $error("sequencer step out of range");

    // Row position never takes the unused code
    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_FIRST) || (r_pos == POS_SECOND) || (r_pos == POS_INNER))
        else $error("row position out of range");
`endif

endmodule
